@@ sv/twlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package twlc_pkg;

	// geometry: 64-byte blocks, 16 words each
	localparam int WPB    = 16;
	localparam int WIDX   = 4;
	localparam int CNT_W  = 5;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [2:0] CFG_MEM_RD = 3'd0;
	localparam logic [2:0] CFG_MEM_WR = 3'd1;
	localparam logic [2:0] CFG_L2_RD  = 3'd2;
	localparam logic [2:0] CFG_L2_WR  = 3'd3;
	localparam logic [2:0] CFG_L1_RD  = 3'd4;
	localparam logic [2:0] CFG_L1_WR  = 3'd5;

	// block mover status toward the sequencer
	typedef struct packed {
		logic            busy;
		logic [WIDX-1:0] rd_idx;
		logic            wr_en;
		logic [WIDX-1:0] wr_idx;
		logic            done;
	} mv_t;

	typedef struct packed {
		logic       v;
		logic       d;
		logic [2:0] tag;
	} l1_way_t;

	typedef struct packed {
		logic             lru;
		l1_way_t [1:0]    w;
	} l1_row_t;

	typedef struct packed {
		logic       v;
		logic       d;
		logic [1:0] tag;
	} l2_way_t;

	typedef struct packed {
		logic             lru;
		l2_way_t [1:0]    w;
	} l2_row_t;

endpackage

`default_nettype wire

@@ sv/twlc_mover.sv @@
`timescale 1ns / 1ps
`default_nettype none

module twlc_mover
	import twlc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output mv_t  mv
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1;
	logic [WIDX-1:0]  idx_s1;
	logic             rd_go;

	assign rd_go = busy_q && (cnt_q < CNT_W'(WPB));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= rd_go;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (rd_go)
					cnt_q <= cnt_q + CNT_W'(1);
				else if (!v_s1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[WIDX-1:0];
	end

	assign mv.busy   = busy_q;
	assign mv.rd_idx = cnt_q[WIDX-1:0];
	assign mv.wr_en  = v_s1;
	assign mv.wr_idx = idx_s1;
	assign mv.done   = busy_q && !rd_go && !v_s1;

endmodule

`default_nettype wire

@@ sv/two_level_writeback_cache_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+------------------------------
// in       | in  | in_valid / in_stall | op, address, write_data
// out      | out | out_valid/out_stall | read_data, total_time
// cfg      | in  | cfg_write           | cfg_index, cfg_data
//
// An L1 hit goes through state read, tag check and update; a read hit adds a
// step for the data word. Each block transfer in S_COPY runs start, 16 word
// reads, the last write and done; the path of a miss depends on victims and
// L2 outcome.
// Reset runs a clearing pass over 16384 main memory words and the tag state;
// a restart runs the pass over the tag state only. No item is taken meanwhile.
// A waiting result sits in the output register while the next item is worked.

module two_level_writeback_cache_unit
	import twlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] address,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [31:0] total_time,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_L1_TAG, S_L1_HIT, S_L1_RD, S_L2_LOOK, S_L2_TAG,
		S_L2_FILL, S_L2_BODY, S_L1_WB, S_L1_FILL, S_COPY, S_DONE
	} state_t;

	typedef enum logic [1:0] {LOC_L1, LOC_L2, LOC_MM, LOC_TB} loc_t;

	state_t      state_q, cp_next_q;
	loc_t        cp_src_q, cp_dst_q;
	logic [1:0]  op_q;
	logic [15:0] addr_q;
	logic [31:0] wd_q, rd_q, time_q;
	logic [9:0]  cost_q [6];
	logic [13:0] clr_q;
	logic        clr_mem_q;
	l1_row_t     r1_q;
	logic        way1_q, vic1_q;
	logic [2:0]  vtag1_q;
	logic [9:0]  l2_blk_q, mm_blk_q;
	logic        l2_wr_q;
	logic [7:0]  l1_line_q;
	logic [8:0]  l2_line_q;
	logic        mv_start_q;
	logic        out_valid_q;
	logic [31:0] read_data_q, total_time_q;
	mv_t         mv;

	// state and data stores
	l1_row_t     l1s_mem [128];
	l1_row_t     l1s_rd_q, l1s_wdata;
	logic [6:0]  l1s_raddr, l1s_waddr;
	logic        l1s_we;
	l2_row_t     l2s_mem [256];
	l2_row_t     l2s_rd_q, l2s_wdata;
	logic [7:0]  l2s_waddr;
	logic        l2s_we;
	logic [31:0] l1d_mem [4096];
	logic [31:0] l1d_rd_q, l1d_wdata;
	logic [11:0] l1d_raddr, l1d_waddr;
	logic        l1d_we;
	logic [31:0] l2d_mem [8192];
	logic [31:0] l2d_rd_q;
	logic [12:0] l2d_waddr;
	logic        l2d_we;
	logic [31:0] mm_mem [16384];
	logic [31:0] mm_rd_q, mm_wdata;
	logic [13:0] mm_waddr;
	logic        mm_we;
	logic [31:0] tb_mem [WPB];
	logic [31:0] tb_rd_q;
	logic        tb_we;
	logic [31:0] src_data;

	// tag check results
	logic        h10, h11, hit1;
	logic        h20, h21, hit2, way2, vic2;
	l2_row_t     n2;
	l1_row_t     n1;
	logic        clr_end;

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign total_time = total_time_q;

	twlc_mover u_mover (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mv_start_q),
		.mv     (mv)
	);

	// L1 tag compare: first matching way wins
	assign h10  = l1s_rd_q.w[0].v && (l1s_rd_q.w[0].tag == addr_q[15:13]);
	assign h11  = l1s_rd_q.w[1].v && (l1s_rd_q.w[1].tag == addr_q[15:13]);
	assign hit1 = h10 || h11;

	// L2 tag compare, victim pick and updated row
	assign h20  = l2s_rd_q.w[0].v && (l2s_rd_q.w[0].tag == l2_blk_q[9:8]);
	assign h21  = l2s_rd_q.w[1].v && (l2s_rd_q.w[1].tag == l2_blk_q[9:8]);
	assign hit2 = h20 || h21;
	assign way2 = hit2 ? !h20 : l2s_rd_q.lru;
	assign vic2 = !hit2 && l2s_rd_q.w[way2].v && l2s_rd_q.w[way2].d;

	always_comb begin
		n2 = l2s_rd_q;
		n2.lru = !way2;
		if (!hit2) begin
			n2.w[way2].v   = 1'b1;
			n2.w[way2].d   = 1'b0;
			n2.w[way2].tag = l2_blk_q[9:8];
		end
		if (l2_wr_q)
			n2.w[way2].d = 1'b1;
	end

	always_comb begin
		n1 = r1_q;
		n1.lru = !way1_q;
		n1.w[way1_q].d = r1_q.w[way1_q].d | (op_q == OP_WRITE);
	end

	assign clr_end = clr_mem_q ? (clr_q == 14'h3FFF) : (clr_q == 14'd255);

	// source word of a block transfer, in the cycle after its read
	always_comb begin
		case (cp_src_q)
			LOC_L1:  src_data = l1d_rd_q;
			LOC_L2:  src_data = l2d_rd_q;
			LOC_MM:  src_data = mm_rd_q;
			LOC_TB:  src_data = tb_rd_q;
			default: src_data = '0;
		endcase
	end

	// memory port steering
	always_comb begin
		logic cp_wr;
		cp_wr = (state_q == S_COPY) && mv.wr_en;
		l1s_raddr = address[12:6];
		l1s_we    = 1'b0;
		l1s_waddr = addr_q[12:6];
		l1s_wdata = n1;
		l2s_we    = 1'b0;
		l2s_waddr = l2_blk_q[7:0];
		l2s_wdata = n2;
		l1d_raddr = {l1_line_q, mv.rd_idx};
		l1d_we    = cp_wr && (cp_dst_q == LOC_L1);
		l1d_waddr = {l1_line_q, mv.wr_idx};
		l1d_wdata = src_data;
		l2d_we    = cp_wr && (cp_dst_q == LOC_L2);
		l2d_waddr = {l2_line_q, mv.wr_idx};
		mm_we     = cp_wr && (cp_dst_q == LOC_MM);
		mm_waddr  = {mm_blk_q, mv.wr_idx};
		mm_wdata  = src_data;
		tb_we     = cp_wr && (cp_dst_q == LOC_TB);
		case (state_q)
			S_CLR: begin
				l1s_we    = 1'b1;
				l1s_waddr = clr_q[6:0];
				l1s_wdata = '0;
				l2s_we    = 1'b1;
				l2s_waddr = clr_q[7:0];
				l2s_wdata = '0;
				mm_we     = clr_mem_q;
				mm_waddr  = clr_q;
				mm_wdata  = '0;
			end
			S_L2_TAG: begin
				l2s_we = 1'b1;
			end
			S_L1_HIT: begin
				l1s_we    = 1'b1;
				l1d_raddr = {addr_q[12:6], way1_q, addr_q[5:2]};
				l1d_we    = (op_q == OP_WRITE);
				l1d_waddr = {addr_q[12:6], way1_q, addr_q[5:2]};
				l1d_wdata = wd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (l1s_we)
			l1s_mem[l1s_waddr] <= l1s_wdata;
		l1s_rd_q <= l1s_mem[l1s_raddr];
	end

	always_ff @(posedge clk) begin
		if (l2s_we)
			l2s_mem[l2s_waddr] <= l2s_wdata;
		l2s_rd_q <= l2s_mem[l2_blk_q[7:0]];
	end

	always_ff @(posedge clk) begin
		if (l1d_we)
			l1d_mem[l1d_waddr] <= l1d_wdata;
		l1d_rd_q <= l1d_mem[l1d_raddr];
	end

	always_ff @(posedge clk) begin
		if (l2d_we)
			l2d_mem[l2d_waddr] <= src_data;
		l2d_rd_q <= l2d_mem[{l2_line_q, mv.rd_idx}];
	end

	always_ff @(posedge clk) begin
		if (mm_we)
			mm_mem[mm_waddr] <= mm_wdata;
		mm_rd_q <= mm_mem[{mm_blk_q, mv.rd_idx}];
	end

	always_ff @(posedge clk) begin
		if (tb_we)
			tb_mem[mv.wr_idx] <= src_data;
		tb_rd_q <= tb_mem[mv.rd_idx];
	end

	// cost registers; writes must come only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q[CFG_MEM_RD] <= 10'd100;
			cost_q[CFG_MEM_WR] <= 10'd50;
			cost_q[CFG_L2_RD]  <= 10'd10;
			cost_q[CFG_L2_WR]  <= 10'd5;
			cost_q[CFG_L1_RD]  <= 10'd1;
			cost_q[CFG_L1_WR]  <= 10'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MEM_RD: cost_q[CFG_MEM_RD] <= cfg_data;
				CFG_MEM_WR: cost_q[CFG_MEM_WR] <= cfg_data;
				CFG_L2_RD:  cost_q[CFG_L2_RD]  <= cfg_data;
				CFG_L2_WR:  cost_q[CFG_L2_WR]  <= cfg_data;
				CFG_L1_RD:  cost_q[CFG_L1_RD]  <= cfg_data;
				CFG_L1_WR:  cost_q[CFG_L1_WR]  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer. A block transfer is started by moving to S_COPY with source,
	// destination and the state to resume at; the mover streams 16 words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cp_next_q    <= S_IDLE;
			cp_src_q     <= LOC_L1;
			cp_dst_q     <= LOC_L1;
			clr_q        <= '0;
			clr_mem_q    <= 1'b1;
			time_q       <= '0;
			mv_start_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			op_q         <= '0;
			addr_q       <= '0;
			wd_q         <= '0;
			rd_q         <= '0;
			r1_q         <= '0;
			way1_q       <= 1'b0;
			vic1_q       <= 1'b0;
			vtag1_q      <= '0;
			l2_blk_q     <= '0;
			l2_wr_q      <= 1'b0;
			l1_line_q    <= '0;
			l2_line_q    <= '0;
			mm_blk_q     <= '0;
			read_data_q  <= '0;
			total_time_q <= '0;
		end else begin
			// drop the result once the transfer is taken; S_DONE reloads it
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (clr_end) begin
						clr_q   <= '0;
						state_q <= clr_mem_q ? S_IDLE : S_DONE;
						clr_mem_q <= 1'b0;
					end else begin
						clr_q <= clr_q + 14'd1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= op;
						addr_q <= {address[15:2], 2'b00};
						wd_q   <= write_data;
						rd_q   <= '0;
						case (op)
							OP_READ, OP_WRITE: state_q <= S_L1_TAG;
							OP_RESTART: begin
								time_q  <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_L1_TAG: begin
					r1_q <= l1s_rd_q;
					if (hit1) begin
						way1_q  <= !h10;
						state_q <= S_L1_HIT;
					end else begin
						// miss: fetch the block from L2 first, victim later
						way1_q   <= l1s_rd_q.lru;
						vic1_q   <= l1s_rd_q.w[l1s_rd_q.lru].v && l1s_rd_q.w[l1s_rd_q.lru].d;
						vtag1_q  <= l1s_rd_q.w[l1s_rd_q.lru].tag;
						l1_line_q <= {addr_q[12:6], l1s_rd_q.lru};
						l2_blk_q <= addr_q[15:6];
						l2_wr_q  <= 1'b0;
						state_q  <= S_L2_LOOK;
					end
				end
				S_L2_LOOK: state_q <= S_L2_TAG;
				S_L2_TAG: begin
					l2_line_q <= {l2_blk_q[7:0], way2};
					if (hit2) begin
						state_q <= S_L2_BODY;
					end else begin
						time_q <= time_q + 32'(cost_q[CFG_MEM_RD])
						          + (vic2 ? 32'(cost_q[CFG_MEM_WR]) : 32'd0);
						if (vic2) begin
							// write the L2 victim back to its own block
							mm_blk_q   <= {l2s_rd_q.w[way2].tag, l2_blk_q[7:0]};
							cp_src_q   <= LOC_L2;
							cp_dst_q   <= LOC_MM;
							cp_next_q  <= l2_wr_q ? S_L2_BODY : S_L2_FILL;
							mv_start_q <= 1'b1;
							state_q    <= S_COPY;
						end else begin
							state_q <= l2_wr_q ? S_L2_BODY : S_L2_FILL;
						end
					end
				end
				S_L2_FILL: begin
					mm_blk_q   <= l2_blk_q;
					cp_src_q   <= LOC_MM;
					cp_dst_q   <= LOC_L2;
					cp_next_q  <= S_L2_BODY;
					mv_start_q <= 1'b1;
					state_q    <= S_COPY;
				end
				S_L2_BODY: begin
					mv_start_q <= 1'b1;
					state_q    <= S_COPY;
					if (l2_wr_q) begin
						time_q    <= time_q + 32'(cost_q[CFG_L2_WR]);
						cp_src_q  <= LOC_L1;
						cp_dst_q  <= LOC_L2;
						cp_next_q <= S_L1_FILL;
					end else begin
						time_q    <= time_q + 32'(cost_q[CFG_L2_RD]);
						cp_src_q  <= LOC_L2;
						cp_dst_q  <= LOC_TB;
						cp_next_q <= vic1_q ? S_L1_WB : S_L1_FILL;
					end
				end
				S_L1_WB: begin
					l2_blk_q <= {vtag1_q, addr_q[12:6]};
					l2_wr_q  <= 1'b1;
					state_q  <= S_L2_LOOK;
				end
				S_L1_FILL: begin
					r1_q.w[way1_q].v   <= 1'b1;
					r1_q.w[way1_q].d   <= 1'b0;
					r1_q.w[way1_q].tag <= addr_q[15:13];
					cp_src_q   <= LOC_TB;
					cp_dst_q   <= LOC_L1;
					cp_next_q  <= S_L1_HIT;
					mv_start_q <= 1'b1;
					state_q    <= S_COPY;
				end
				S_COPY: begin
					// the start pulse lasts one cycle
					mv_start_q <= 1'b0;
					if (mv.done)
						state_q <= cp_next_q;
				end
				S_L1_HIT: begin
					if (op_q == OP_WRITE) begin
						time_q  <= time_q + 32'(cost_q[CFG_L1_WR]);
						state_q <= S_DONE;
					end else begin
						state_q <= S_L1_RD;
					end
				end
				S_L1_RD: begin
					rd_q    <= l1d_rd_q;
					time_q  <= time_q + 32'(cost_q[CFG_L1_RD]);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						read_data_q  <= rd_q;
						total_time_q <= time_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no item is taken while a block transfer is in flight
	assert property (@(posedge clk) disable iff (!arst_n) !in_stall |-> !mv.busy)
		else $error("item accepted during block transfer");

	// mover writes land only inside a transfer
	assert property (@(posedge clk) disable iff (!arst_n) mv.wr_en |-> state_q == S_COPY)
		else $error("mover write outside transfer");

	// a restart always reports zero time
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && op_q == OP_RESTART) |-> time_q == 32'd0)
		else $error("restart result with nonzero time");

	// a new result only loads after the sequencer finished an item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result without finished item");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import twlc_pkg::*;

	localparam int BLK_BYTES   = 64;
	localparam int WORDS_PB    = 16;
	localparam int L1_SETS     = 128;
	localparam int L2_SETS     = 256;
	localparam int MEM_WORDS   = 16384;
	localparam int NUM_RANDOM  = 1700;
	localparam int STALL_LIMIT = 60000;

	// op code with no function: leaves all state alone
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] address;
		logic [31:0] write_data;
	} access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] total_time;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic [15:0] address = '0;
	logic [31:0] write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic [31:0] total_time;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;

	two_level_writeback_cache_unit i_dut (.*);

	always #5 clk = ~clk;

	// shadow of the cache hierarchy
	logic [9:0]  cost [6];
	logic [2:0]  l1_tag [2*L1_SETS];
	logic        l1_v [2*L1_SETS];
	logic        l1_d [2*L1_SETS];
	logic        l1_lru [L1_SETS];
	logic [31:0] l1_data [2*L1_SETS*WORDS_PB];
	logic [1:0]  l2_tag [2*L2_SETS];
	logic        l2_v [2*L2_SETS];
	logic        l2_d [2*L2_SETS];
	logic        l2_lru [L2_SETS];
	logic [31:0] l2_data [2*L2_SETS*WORDS_PB];
	logic [31:0] mem [MEM_WORDS];
	logic [31:0] clock_now;

	access_t  pending_accesses[$];
	outcome_t expected_outcomes[$];
	logic     busy_run = 1'b0;
	int       mismatches = 0;
	int       idle_cycles = 0;
	bit       timed_out = 1'b0;

	function automatic void drop_lines();
		for (int i = 0; i < 2*L1_SETS; i++) begin
			l1_v[i] = 1'b0; l1_d[i] = 1'b0;
		end
		for (int i = 0; i < L1_SETS; i++) l1_lru[i] = 1'b0;
		for (int i = 0; i < 2*L2_SETS; i++) begin
			l2_v[i] = 1'b0; l2_d[i] = 1'b0;
		end
		for (int i = 0; i < L2_SETS; i++) l2_lru[i] = 1'b0;
	endfunction

	// move one block between L2 and the level above; blk is in/out
	function automatic void l2_block(int unsigned addr, ref logic [31:0] blk [WORDS_PB],
			input bit wr);
		int unsigned set, tag, way, line, base;
		bit hit;
		logic [31:0] fill [WORDS_PB];
		set = (addr / BLK_BYTES) % L2_SETS;
		tag = addr / (BLK_BYTES * L2_SETS);
		hit = 0;
		way = 0;
		for (int w = 0; w < 2; w++)
			if (!hit && l2_v[set*2+w] && l2_tag[set*2+w] == tag) begin
				hit = 1; way = w;
			end
		if (!hit) begin
			// fetch first, then evict the victim to its own address
			base = (addr / BLK_BYTES) * WORDS_PB;
			for (int i = 0; i < WORDS_PB; i++) fill[i] = mem[(base + i) % MEM_WORDS];
			clock_now += cost[CFG_MEM_RD];
			way = 32'(l2_lru[set]);
			line = set*2 + way;
			if (l2_v[line] && l2_d[line]) begin
				base = (l2_tag[line] * L2_SETS + set) * WORDS_PB;
				for (int i = 0; i < WORDS_PB; i++)
					mem[(base + i) % MEM_WORDS] = l2_data[line*WORDS_PB + i];
				clock_now += cost[CFG_MEM_WR];
			end
			for (int i = 0; i < WORDS_PB; i++) l2_data[line*WORDS_PB + i] = fill[i];
			l2_v[line] = 1'b1; l2_d[line] = 1'b0; l2_tag[line] = 2'(tag);
		end
		line = set*2 + way;
		l2_lru[set] = (way == 0);
		if (wr) begin
			for (int i = 0; i < WORDS_PB; i++) l2_data[line*WORDS_PB + i] = blk[i];
			l2_d[line] = 1'b1;
			clock_now += cost[CFG_L2_WR];
		end else begin
			for (int i = 0; i < WORDS_PB; i++) blk[i] = l2_data[line*WORDS_PB + i];
			clock_now += cost[CFG_L2_RD];
		end
	endfunction

	function automatic logic [31:0] l1_word(int unsigned addr, logic [31:0] data, bit wr);
		int unsigned set, tag, wd, way, line;
		bit hit;
		logic [31:0] fill [WORDS_PB];
		logic [31:0] victim [WORDS_PB];
		set = (addr / BLK_BYTES) % L1_SETS;
		tag = addr / (BLK_BYTES * L1_SETS);
		wd = (addr % BLK_BYTES) / 4;
		hit = 0;
		way = 0;
		for (int w = 0; w < 2; w++)
			if (!hit && l1_v[set*2+w] && l1_tag[set*2+w] == tag) begin
				hit = 1; way = w;
			end
		if (!hit) begin
			l2_block(addr, fill, 0);
			way = 32'(l1_lru[set]);
			line = set*2 + way;
			if (l1_v[line] && l1_d[line]) begin
				for (int i = 0; i < WORDS_PB; i++) victim[i] = l1_data[line*WORDS_PB + i];
				l2_block((l1_tag[line] * L1_SETS + set) * BLK_BYTES, victim, 1);
			end
			for (int i = 0; i < WORDS_PB; i++) l1_data[line*WORDS_PB + i] = fill[i];
			l1_v[line] = 1'b1; l1_d[line] = 1'b0; l1_tag[line] = 3'(tag);
		end
		line = set*2 + way;
		l1_lru[set] = (way == 0);
		if (wr) begin
			l1_data[line*WORDS_PB + wd] = data;
			l1_d[line] = 1'b1;
			clock_now += cost[CFG_L1_WR];
			return '0;
		end
		clock_now += cost[CFG_L1_RD];
		return l1_data[line*WORDS_PB + wd];
	endfunction

	function automatic outcome_t cache_access(access_t a);
		outcome_t r;
		int unsigned addr;
		addr = {a.address[15:2], 2'b00};
		r.read_data = '0;
		if (a.op == OP_READ)
			r.read_data = l1_word(addr, '0, 0);
		else if (a.op == OP_WRITE)
			void'(l1_word(addr, a.write_data, 1));
		else if (a.op == OP_RESTART) begin
			drop_lines();
			clock_now = '0;
		end
		r.total_time = clock_now;
		return r;
	endfunction

	// idle about a third of the time, except during the busy stretch
	function automatic logic idle_roll();
		return !busy_run && ($urandom_range(99) < 34);
	endfunction

	// driver: advance to the next access once the current one transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_accesses.size() > 0 && !idle_roll()) begin
					access_t a;
					a = pending_accesses.pop_front();
					expected_outcomes.push_back(cache_access(a));
					op <= a.op;
					address <= a.address;
					write_data <= a.write_data;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= idle_roll();
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result data=%h time=%h", read_data, total_time);
				end else begin
					outcome_t e;
					e = expected_outcomes.pop_front();
					if (e.read_data !== read_data || e.total_time !== total_time) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected data=%h time=%h got data=%h time=%h",
								e.read_data, e.total_time, read_data, total_time);
					end
				end
			end
		end
	end

	function automatic access_t make_access(logic [1:0] o, logic [15:0] a, logic [31:0] d);
		access_t x;
		x.op = o; x.address = a; x.write_data = d;
		return x;
	endfunction

	// conflict-heavy address: few tags over few sets so victims churn
	function automatic logic [15:0] hot_address();
		logic [15:0] a;
		a = 16'($urandom);
		if ($urandom_range(3) != 0) begin
			a[15:14] = 2'($urandom_range(3));
			a[13:6] = 8'($urandom_range(3));
		end
		return a;
	endfunction

	task automatic drain();
		while (pending_accesses.size() > 0 || expected_outcomes.size() > 0 || in_valid)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cost(logic [2:0] idx, logic [9:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		cost[idx] = val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic random_phase(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 45)
				pending_accesses.push_back(make_access(OP_READ, hot_address(), '0));
			else if (r < 92)
				pending_accesses.push_back(make_access(OP_WRITE, hot_address(), $urandom));
			else if (r < 96)
				pending_accesses.push_back(make_access(OP_RESTART, 16'($urandom), $urandom));
			else
				pending_accesses.push_back(make_access(OP_NONE, 16'($urandom), $urandom));
		end
	endtask

	initial begin
		cost[CFG_MEM_RD] = 100; cost[CFG_MEM_WR] = 50;
		cost[CFG_L2_RD] = 10; cost[CFG_L2_WR] = 5;
		cost[CFG_L1_RD] = 1; cost[CFG_L1_WR] = 1;
		for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
		drop_lines();
		clock_now = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: cold read, extremes, write then evict through both levels
		pending_accesses.push_back(make_access(OP_READ, 16'h0000, '0));
		pending_accesses.push_back(make_access(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF));
		pending_accesses.push_back(make_access(OP_READ, 16'hFFFC, '0));
		pending_accesses.push_back(make_access(OP_WRITE, 16'h0003, 32'hA5A5_5A5A));
		for (int k = 1; k < 6; k++)
			pending_accesses.push_back(make_access(OP_WRITE, 16'(k * 16'h2000), 32'(k)));
		for (int k = 0; k < 6; k++)
			pending_accesses.push_back(make_access(OP_READ, 16'(k * 16'h2000), '0));
		pending_accesses.push_back(make_access(OP_NONE, 16'h1234, 32'h5555_5555));
		pending_accesses.push_back(make_access(OP_RESTART, 16'h0, '0));
		pending_accesses.push_back(make_access(OP_READ, 16'h2000, '0));
		pending_accesses.push_back(make_access(OP_WRITE, 16'h0040, 32'h0000_0001));
		pending_accesses.push_back(make_access(OP_READ, 16'h0040, '0));
		drain();

		write_cost(CFG_MEM_RD, 10'd1023); write_cost(CFG_MEM_WR, 10'd1023);
		write_cost(CFG_L2_RD, 10'd1023); write_cost(CFG_L2_WR, 10'd1023);
		write_cost(CFG_L1_RD, 10'd1023); write_cost(CFG_L1_WR, 10'd1023);
		random_phase(400);
		drain();

		for (int i = 0; i < 6; i++) write_cost(3'(i), 10'd0);
		random_phase(300);
		drain();

		for (int i = 0; i < 6; i++) write_cost(3'(i), 10'($urandom));
		busy_run = 1'b1;
		random_phase(300);
		drain();
		busy_run = 1'b0;
		random_phase(700);
		drain();

		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// watchdog; allow for the clearing pass after reset
	always @(posedge clk) begin
		if (arst_n && idle_cycles > STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("testbench: errors");
			$finish;
		end
	end

endmodule

@@ sim.f @@
sv/twlc_pkg.sv
sv/twlc_mover.sv
sv/two_level_writeback_cache_unit.sv
bench/testbench.sv
